// ===== src/rmp_pkg.sv =====
package rmp_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DEF_MAX_BLOCK  = 64;
    localparam int MIN_BLOCK      = 4;

    localparam int PIX_W  = 8;
    localparam int SUM_W  = 20;
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Register indexes on the configuration port (byte address is four times this).
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_RECT_X       = 3'd2;
    localparam logic [2:0] REG_RECT_Y       = 3'd3;
    localparam logic [2:0] REG_RECT_W       = 3'd4;
    localparam logic [2:0] REG_RECT_H       = 3'd5;
    localparam logic [2:0] REG_BLOCK_SIZE   = 3'd6;

    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd1920;
    localparam logic [11:0] RST_FRAME_HEIGHT = 12'd1080;
    localparam logic [10:0] RST_RECT_X       = 11'd0;
    localparam logic [10:0] RST_RECT_Y       = 11'd0;
    localparam logic [11:0] RST_RECT_W       = 12'd0;
    localparam logic [11:0] RST_RECT_H       = 12'd0;
    localparam logic [7:0]  RST_BLOCK_SIZE   = 8'd16;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== src/rmp_divider.sv =====
module rmp_divider
    import rmp_pkg::*;
#(
    parameter int DIVISOR_W = 13
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SUM_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output div_status_t          status,
    output logic [PIX_W-1:0]     quotient
);

    localparam int STEP_W = $clog2(PIX_W);
    localparam int WIDE_W = SUM_W + PIX_W;

    logic                 busy_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [SUM_W-1:0]     rem_reg;
    logic [DIVISOR_W-1:0] div_reg;
    logic [PIX_W-1:0]     q_reg;

    logic [WIDE_W-1:0]    shifted;
    logic                 take;
    logic [SUM_W-1:0]     rem_next;
    logic [PIX_W-1:0]     q_next;

    // Restoring division, one quotient bit per cycle from the top; the mean
    // always fits in a pixel, so only PIX_W steps are needed.
    always_comb
    begin
        shifted  = WIDE_W'(div_reg) << step_reg;
        take     = WIDE_W'(rem_reg) >= shifted;
        rem_next = take ? (rem_reg - shifted[SUM_W-1:0]) : rem_reg;
        q_next   = {q_reg[PIX_W-2:0], take};
    end

    assign status.busy = busy_reg;
    assign status.done = busy_reg && (step_reg == '0);
    assign quotient    = q_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(PIX_W - 1);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            div_reg <= divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

endmodule

// ===== src/rectangle_mosaic_pixelator.sv =====
// Channel   Direction  Handshake                  Payload
// s_*       in         s_tvalid / s_tready        s_tdata[7:0] pixel_in, s_tuser[0] mode
// m_*       out        m_tvalid / m_tready        m_tdata[7:0] pixel_out, m_tlast frame_end
// APB       in         psel, penable, pwrite      seven registers at 4*index
//
// Requests are normally taken back to back. The request that completes a tile holds
// s_tready low while the serial divider forms the tile mean. No request is taken
// in the first cycle after reset or in the cycle after each register write.
// Line, sum and mean stores are never cleared; every read hits an entry written
// earlier in the same frame. A stalled output keeps an emitting request in the
// second stage, and s_tready stays low until the output register frees up.
module rectangle_mosaic_pixelator
    import rmp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_BLOCK  = DEF_MAX_BLOCK
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] pixel_in
    input  logic [0:0]        s_tuser,   // [0] mode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] pixel_out
    output logic              m_tlast
);

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int FWW        = $clog2(MAX_WIDTH + 1);
    localparam int RW         = $clog2(MAX_HEIGHT);
    localparam int FHW        = $clog2(MAX_HEIGHT + 1);
    localparam int BSW        = $clog2(MAX_BLOCK + 1);
    localparam int TCW        = $clog2(MAX_BLOCK);
    localparam int LRW        = $clog2(MAX_BLOCK);
    localparam int TILE_SLOTS = (MAX_WIDTH + MIN_BLOCK - 1) / MIN_BLOCK;
    localparam int TW         = $clog2(TILE_SLOTS);
    localparam int MEAN_DEPTH = 2 * TILE_SLOTS;
    localparam int MAW        = $clog2(MEAN_DEPTH);
    localparam int LINE_DEPTH = MAX_WIDTH * MAX_BLOCK;
    localparam int LAW        = $clog2(LINE_DEPTH);
    localparam int CNTW       = $clog2(MAX_BLOCK * MAX_BLOCK + 1);

    // Configuration registers.
    logic [11:0] fw_reg, fh_reg, rw_reg, rh_reg;
    logic [10:0] rx_reg, ry_reg;
    logic [7:0]  bs_reg;
    logic        cfg_wr;
    logic        cfg_wait_reg;

    // Geometry latched at frame start.
    logic [FWW-1:0] g_fw_reg, g_rxe_reg;
    logic [CW-1:0]  g_rx_reg;
    logic [FHW-1:0] g_fh_reg, g_rye_reg;
    logic [RW-1:0]  g_ry_reg;
    logic [BSW-1:0] g_bs_reg;
    logic [TCW-1:0] g_bsm1_reg;
    logic [15:0]    t_fw, t_fh, t_rx, t_ry, t_rw, t_rh, t_bs;

    // Position counters.
    logic [FHW-1:0] in_row_reg, out_row_reg;
    logic [CW-1:0]  in_col_reg, out_col_reg;
    logic [LRW-1:0] in_lrow_reg, out_lrow_reg;
    logic [TCW-1:0] in_tcol_reg, in_trow_reg, out_tcol_reg, out_trow_reg;
    logic [TW-1:0]  in_tile_reg, out_tile_reg;
    logic           in_kpar_reg, out_kpar_reg;

    logic [TCW-1:0] in_tcol_cur, in_trow_cur, out_tcol_cur, out_trow_cur;
    logic [TW-1:0]  in_tile_cur, out_tile_cur;
    logic           in_kpar_cur, out_kpar_cur;

    logic accept, frame_phase, is_pix, emit0, acc0, in_inr, out_inr;
    logic in_clear, in_done, in_col_last, out_col_last, out_last;
    logic [TCW:0]      tw, th;
    logic [CNTW-1:0]   tile_cnt;
    logic [LAW-1:0]    line_wa, line_ra;
    logic [MAW-1:0]    mean_ra;

    // Stores.
    logic [PIX_W-1:0] line_mem  [LINE_DEPTH];
    logic [SUM_W-1:0] sums_mem  [TILE_SLOTS];
    logic [PIX_W-1:0] means_mem [MEAN_DEPTH];
    logic [PIX_W-1:0] line_rd_reg, means_rd_reg;
    logic [SUM_W-1:0] sums_rd_reg;

    // Second stage.
    logic             s1_valid_reg, s1_emit_reg, s1_mean_reg, s1_last_reg;
    logic             s1_acc_reg, s1_clear_reg, s1_done_reg, s1_fwd_reg, s1_kpar_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [TW-1:0]    s1_tile_reg;
    logic [CNTW-1:0]  s1_cnt_reg;
    logic [SUM_W-1:0] fwd_sum_reg, s1_sum;
    logic             s1_go, out_free;

    // Divider.
    div_status_t      div_status;
    logic [PIX_W-1:0] div_q;
    logic [MAW-1:0]   div_idx_reg;
    logic             div_start;

    // Output register.
    logic             out_valid_reg, out_last_reg;
    logic [PIX_W-1:0] out_data_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg       <= RST_FRAME_WIDTH;
            fh_reg       <= RST_FRAME_HEIGHT;
            rx_reg       <= RST_RECT_X;
            ry_reg       <= RST_RECT_Y;
            rw_reg       <= RST_RECT_W;
            rh_reg       <= RST_RECT_H;
            bs_reg       <= RST_BLOCK_SIZE;
            cfg_wait_reg <= 1'b1;
        end
        else
        begin
            cfg_wait_reg <= cfg_wr;
            if (cfg_wr)
            begin
                unique case (paddr[APB_AW-1:2])
                    REG_FRAME_WIDTH:  fw_reg <= pwdata[11:0];
                    REG_FRAME_HEIGHT: fh_reg <= pwdata[11:0];
                    REG_RECT_X:       rx_reg <= pwdata[10:0];
                    REG_RECT_Y:       ry_reg <= pwdata[10:0];
                    REG_RECT_W:       rw_reg <= pwdata[11:0];
                    REG_RECT_H:       rh_reg <= pwdata[11:0];
                    REG_BLOCK_SIZE:   bs_reg <= pwdata[7:0];
                    default:          ;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (paddr[APB_AW-1:2])
            REG_FRAME_WIDTH:  prdata = APB_DW'(fw_reg);
            REG_FRAME_HEIGHT: prdata = APB_DW'(fh_reg);
            REG_RECT_X:       prdata = APB_DW'(rx_reg);
            REG_RECT_Y:       prdata = APB_DW'(ry_reg);
            REG_RECT_W:       prdata = APB_DW'(rw_reg);
            REG_RECT_H:       prdata = APB_DW'(rh_reg);
            REG_BLOCK_SIZE:   prdata = APB_DW'(bs_reg);
            default:          prdata = '0;
        endcase
    end

    // Clamp and clip the geometry; the rectangle end is kept exclusive.
    always_comb
    begin
        t_fw = 16'(fw_reg);
        if (t_fw == 16'd0)
        begin
            t_fw = 16'd1;
        end
        else if (t_fw > 16'(MAX_WIDTH))
        begin
            t_fw = 16'(MAX_WIDTH);
        end
        t_fh = 16'(fh_reg);
        if (t_fh == 16'd0)
        begin
            t_fh = 16'd1;
        end
        else if (t_fh > 16'(MAX_HEIGHT))
        begin
            t_fh = 16'(MAX_HEIGHT);
        end
        t_rx = 16'(rx_reg);
        if (t_rx > t_fw - 16'd1)
        begin
            t_rx = t_fw - 16'd1;
        end
        t_ry = 16'(ry_reg);
        if (t_ry > t_fh - 16'd1)
        begin
            t_ry = t_fh - 16'd1;
        end
        t_rw = 16'(rw_reg);
        if (t_rw > t_fw - t_rx)
        begin
            t_rw = t_fw - t_rx;
        end
        t_rh = 16'(rh_reg);
        if (t_rh > t_fh - t_ry)
        begin
            t_rh = t_fh - t_ry;
        end
        t_bs = 16'(bs_reg);
        if (t_bs < 16'(MIN_BLOCK))
        begin
            t_bs = 16'(MIN_BLOCK);
        end
        else if (t_bs > 16'(MAX_BLOCK))
        begin
            t_bs = 16'(MAX_BLOCK);
        end
    end

    // The geometry follows the registers while no pixel of the frame has arrived.
    always_ff @(posedge clk)
    begin
        if (in_row_reg == '0 && in_col_reg == '0)
        begin
            g_fw_reg   <= FWW'(t_fw);
            g_fh_reg   <= FHW'(t_fh);
            g_rx_reg   <= CW'(t_rx);
            g_ry_reg   <= RW'(t_ry);
            g_rxe_reg  <= FWW'(t_rx + t_rw);
            g_rye_reg  <= FHW'(t_ry + t_rh);
            g_bs_reg   <= BSW'(t_bs);
            g_bsm1_reg <= TCW'(t_bs - 16'd1);
        end
    end

    always_comb
    begin
        out_free    = !out_valid_reg || m_tready;
        s1_go       = s1_valid_reg && (!s1_emit_reg || out_free);
        s_tready    = !cfg_wait_reg && !div_status.busy &&
                      (!s1_valid_reg || (s1_go && !s1_done_reg));
        accept      = s_tvalid && s_tready;

        frame_phase = in_row_reg < g_fh_reg;
        is_pix      = frame_phase && !s_tuser[0];
        emit0       = frame_phase ? (is_pix && in_row_reg >= FHW'(g_bs_reg))
                                  : (out_row_reg < g_fh_reg);

        in_tcol_cur = (in_col_reg == g_rx_reg) ? '0 : in_tcol_reg;
        in_tile_cur = (in_col_reg == g_rx_reg) ? '0 : in_tile_reg;
        in_trow_cur = (in_row_reg == FHW'(g_ry_reg)) ? '0 : in_trow_reg;
        in_kpar_cur = (in_row_reg == FHW'(g_ry_reg)) ? 1'b0 : in_kpar_reg;
        in_inr      = in_col_reg >= g_rx_reg && FWW'(in_col_reg) < g_rxe_reg &&
                      in_row_reg >= FHW'(g_ry_reg) && in_row_reg < g_rye_reg;
        in_clear    = in_tcol_cur == '0 && in_trow_cur == '0;
        in_done     = (in_trow_cur == g_bsm1_reg || in_row_reg == g_rye_reg - 1'b1) &&
                      (in_tcol_cur == g_bsm1_reg || FWW'(in_col_reg) == g_rxe_reg - 1'b1);
        in_col_last = FWW'(in_col_reg) == g_fw_reg - 1'b1;
        acc0        = is_pix && in_inr;
        tw          = {1'b0, in_tcol_cur} + 1'b1;
        th          = {1'b0, in_trow_cur} + 1'b1;
        tile_cnt    = CNTW'(tw * th);

        out_tcol_cur = (out_col_reg == g_rx_reg) ? '0 : out_tcol_reg;
        out_tile_cur = (out_col_reg == g_rx_reg) ? '0 : out_tile_reg;
        out_trow_cur = (out_row_reg == FHW'(g_ry_reg)) ? '0 : out_trow_reg;
        out_kpar_cur = (out_row_reg == FHW'(g_ry_reg)) ? 1'b0 : out_kpar_reg;
        out_inr      = out_col_reg >= g_rx_reg && FWW'(out_col_reg) < g_rxe_reg &&
                       out_row_reg >= FHW'(g_ry_reg) && out_row_reg < g_rye_reg;
        out_col_last = FWW'(out_col_reg) == g_fw_reg - 1'b1;
        out_last     = out_col_last && out_row_reg == g_fh_reg - 1'b1;

        line_wa = LAW'(in_lrow_reg) * LAW'(MAX_WIDTH) + LAW'(in_col_reg);
        line_ra = LAW'(out_lrow_reg) * LAW'(MAX_WIDTH) + LAW'(out_col_reg);
        mean_ra = out_kpar_cur ? (MAW'(TILE_SLOTS) + MAW'(out_tile_cur)) : MAW'(out_tile_cur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_lrow_reg  <= '0;
            in_tcol_reg  <= '0;
            in_trow_reg  <= '0;
            in_tile_reg  <= '0;
            in_kpar_reg  <= 1'b0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_lrow_reg <= '0;
            out_tcol_reg <= '0;
            out_trow_reg <= '0;
            out_tile_reg <= '0;
            out_kpar_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (is_pix)
            begin
                in_tcol_reg <= (in_tcol_cur == g_bsm1_reg) ? '0 : in_tcol_cur + 1'b1;
                in_tile_reg <= in_tile_cur + TW'(in_tcol_cur == g_bsm1_reg);
                if (in_col_last)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + 1'b1;
                    in_lrow_reg <= (in_lrow_reg == LRW'(MAX_BLOCK - 1)) ? '0 : in_lrow_reg + 1'b1;
                    in_trow_reg <= (in_trow_cur == g_bsm1_reg) ? '0 : in_trow_cur + 1'b1;
                    in_kpar_reg <= in_kpar_cur ^ (in_trow_cur == g_bsm1_reg);
                end
                else
                begin
                    in_col_reg <= in_col_reg + 1'b1;
                end
            end
            if (emit0)
            begin
                out_tcol_reg <= (out_tcol_cur == g_bsm1_reg) ? '0 : out_tcol_cur + 1'b1;
                out_tile_reg <= out_tile_cur + TW'(out_tcol_cur == g_bsm1_reg);
                if (out_col_last)
                begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + 1'b1;
                    out_lrow_reg <= (out_lrow_reg == LRW'(MAX_BLOCK - 1)) ? '0
                                                                          : out_lrow_reg + 1'b1;
                    out_trow_reg <= (out_trow_cur == g_bsm1_reg) ? '0 : out_trow_cur + 1'b1;
                    out_kpar_reg <= out_kpar_cur ^ (out_trow_cur == g_bsm1_reg);
                end
                else
                begin
                    out_col_reg <= out_col_reg + 1'b1;
                end
                // The last pixel of the frame returns the row, column and line-row counters to the origin.
                if (out_last)
                begin
                    in_row_reg   <= '0;
                    in_col_reg   <= '0;
                    in_lrow_reg  <= '0;
                    out_row_reg  <= '0;
                    out_col_reg  <= '0;
                    out_lrow_reg <= '0;
                end
            end
        end
    end

    // Stores are read-first, so the line row being overwritten still reads its old pixel.
    always_ff @(posedge clk)
    begin
        if (accept && is_pix)
        begin
            line_mem[line_wa] <= s_tdata;
        end
        if (accept && emit0)
        begin
            line_rd_reg  <= line_mem[line_ra];
            means_rd_reg <= means_mem[mean_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_acc_reg)
        begin
            sums_mem[s1_tile_reg] <= s1_sum;
        end
        if (accept && acc0)
        begin
            sums_rd_reg <= sums_mem[in_tile_cur];
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_status.done)
        begin
            means_mem[div_idx_reg] <= div_q;
        end
    end

    // A sum written back in the same cycle as the next read is forwarded.
    assign s1_sum = (s1_clear_reg ? '0 : (s1_fwd_reg ? fwd_sum_reg : sums_rd_reg)) +
                    SUM_W'(s1_pix_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg  <= emit0;
            s1_mean_reg  <= out_inr;
            s1_last_reg  <= out_last && !frame_phase;
            s1_acc_reg   <= acc0;
            s1_clear_reg <= in_clear;
            s1_done_reg  <= acc0 && in_done;
            s1_pix_reg   <= s_tdata;
            s1_tile_reg  <= in_tile_cur;
            s1_kpar_reg  <= in_kpar_cur;
            s1_cnt_reg   <= tile_cnt;
            s1_fwd_reg   <= s1_go && s1_acc_reg && s1_tile_reg == in_tile_cur;
            fwd_sum_reg  <= s1_sum;
        end
    end

    assign div_start = s1_go && s1_done_reg;

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            div_idx_reg <= s1_kpar_reg ? (MAW'(TILE_SLOTS) + MAW'(s1_tile_reg))
                                       : MAW'(s1_tile_reg);
        end
    end

    rmp_divider #(
        .DIVISOR_W (CNTW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (s1_sum),
        .divisor  (s1_cnt_reg),
        .status   (div_status),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_emit_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emit_reg)
        begin
            out_data_reg <= s1_mean_reg ? means_rd_reg : line_rd_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import rmp_pkg::*;

    typedef struct {
        logic       drain;
        logic [7:0] luma;
    } pix_req_t;

    typedef struct {
        logic [7:0] luma;
        logic       last;
    } pix_res_t;

    localparam int TILE_SLOTS = 512;
    localparam int LIMIT_CYCLES = 2000000;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;   // [7:0] pixel_in
    logic [0:0]        s_tuser;   // [0] mode
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;   // [7:0] pixel_out
    logic              m_tlast;

    pix_req_t    pending_reqs[$];
    pix_res_t    expected_pixels[$];
    int unsigned error_count;
    int unsigned accepted_reqs;
    int unsigned checked_pixels;
    int unsigned frames_done;
    int unsigned phase_count;
    int unsigned cycle_count;

    // Register copies and the geometry latched at the first pixel of a frame.
    int unsigned reg_fw, reg_fh, reg_rx, reg_ry, reg_rw, reg_rh, reg_bs;
    int unsigned geo_fw, geo_fh, geo_rx, geo_ry, geo_rw, geo_rh, geo_bs;
    logic [7:0]  line_mem[0:131071];
    int unsigned tile_acc[0:TILE_SLOTS-1];
    logic [7:0]  tile_avg[0:2*TILE_SLOTS-1];
    int unsigned in_r, in_c, out_r, out_c;

    rectangle_mosaic_pixelator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic bit inside_rect(int unsigned r, int unsigned c);
        return c >= geo_rx && c < geo_rx + geo_rw && r >= geo_ry && r < geo_ry + geo_rh;
    endfunction

    task automatic report(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic latch_frame_geometry();
        geo_fw = clamp_u(reg_fw, 1, 2048);
        geo_fh = clamp_u(reg_fh, 1, 2048);
        geo_rx = reg_rx < geo_fw - 1 ? reg_rx : geo_fw - 1;
        geo_ry = reg_ry < geo_fh - 1 ? reg_ry : geo_fh - 1;
        geo_rw = reg_rw < geo_fw - geo_rx ? reg_rw : geo_fw - geo_rx;
        geo_rh = reg_rh < geo_fh - geo_ry ? reg_rh : geo_fh - geo_ry;
        geo_bs = clamp_u(reg_bs, MIN_BLOCK, 64);
    endtask

    task automatic emit_pixel();
        pix_res_t    res;
        int unsigned t;
        int unsigned k;
        res.last = (out_r == geo_fh - 1) && (out_c == geo_fw - 1);
        if (inside_rect(out_r, out_c))
        begin
            t = (out_c - geo_rx) / geo_bs;
            k = (out_r - geo_ry) / geo_bs;
            res.luma = tile_avg[((k & 1) * TILE_SLOTS + t) % (2 * TILE_SLOTS)];
        end
        else
        begin
            res.luma = line_mem[(out_r % 64) * 2048 + out_c];
        end
        expected_pixels.insert(expected_pixels.size(), res);
        out_c++;
        if (out_c >= geo_fw)
        begin
            out_c = 0;
            out_r++;
        end
        if (res.last)
        begin
            in_r = 0;
            in_c = 0;
            out_r = 0;
            out_c = 0;
        end
    endtask

    task automatic accumulate_tile(int unsigned r, int unsigned c, int unsigned pix);
        int unsigned dc, dr, t, k, tw, th;
        if (inside_rect(r, c))
        begin
            dc = c - geo_rx;
            dr = r - geo_ry;
            t  = (dc / geo_bs) % TILE_SLOTS;
            k  = dr / geo_bs;
            if (dr % geo_bs == 0 && dc % geo_bs == 0)
                tile_acc[t] = 0;
            tile_acc[t] = (tile_acc[t] + pix) & 20'hFFFFF;
            if ((dr % geo_bs == geo_bs - 1 || r == geo_ry + geo_rh - 1) &&
                (dc % geo_bs == geo_bs - 1 || c == geo_rx + geo_rw - 1))
            begin
                tw = geo_rw - (dc / geo_bs) * geo_bs;
                th = geo_rh - k * geo_bs;
                if (tw > geo_bs) tw = geo_bs;
                if (th > geo_bs) th = geo_bs;
                tile_avg[(k & 1) * TILE_SLOTS + t] = 8'(tile_acc[t] / (tw * th));
            end
        end
    endtask

    task automatic mosaic_predict(input pix_req_t req);
        if (in_r < geo_fh)
        begin
            if (!req.drain)
            begin
                if (in_r == 0 && in_c == 0)
                    latch_frame_geometry();
                if (in_r >= geo_bs)
                    emit_pixel();
                line_mem[(in_r % 64) * 2048 + in_c] = req.luma;
                accumulate_tile(in_r, in_c, req.luma);
                in_c++;
                if (in_c >= geo_fw)
                begin
                    in_c = 0;
                    in_r++;
                end
            end
        end
        else if (out_r < geo_fh)
        begin
            emit_pixel();
        end
    endtask

    // Driver: bursts of random length separated by random gaps.
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge clk)
    begin
        pix_req_t req;
        logic     next_valid;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                req.drain = s_tuser[0];
                req.luma  = s_tdata;
                mosaic_predict(req);
                accepted_reqs++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                next_valid = 1'b0;
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_reqs.size() > 0)
                begin
                    req = pending_reqs.pop_front();
                    s_tdata    <= req.luma;
                    s_tuser    <= req.drain;
                    next_valid = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                end
                s_tvalid <= next_valid;
            end
        end
    end

    // Long receiver hold-off, counted here, starts once the stream is under way.
    int unsigned hold_left;
    bit          hold_done;

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted_reqs > 400)
        begin
            hold_left <= 600;
            hold_done <= 1'b1;
        end
    end

    int unsigned stall_style;

    always @(posedge clk)
    begin
        pix_res_t want;
        if (cycle_count % 97 == 0)
            stall_style = $urandom_range(0, 2);
        if (m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                report($sformatf("unexpected pixel %0d last %0b", m_tdata, m_tlast));
            end
            else
            begin
                want = expected_pixels.pop_front();
                checked_pixels++;
                if (m_tdata !== want.luma)
                    report($sformatf("pixel_out %0d, predicted %0d", m_tdata, want.luma));
                if (m_tlast !== want.last)
                    report($sformatf("frame_end %0b, predicted %0b", m_tlast, want.last));
                if (m_tlast === 1'b1)
                    frames_done++;
            end
        end
        case (stall_style)
            0:       m_tready <= (hold_left == 0);
            1:       m_tready <= (hold_left == 0) && ($urandom_range(0, 3) != 0);
            default: m_tready <= (hold_left == 0) && ($urandom_range(0, 9) < 3);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input int unsigned val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx) << 2;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  reg_fw = val & 12'hFFF;
            REG_FRAME_HEIGHT: reg_fh = val & 12'hFFF;
            REG_RECT_X:       reg_rx = val & 11'h7FF;
            REG_RECT_Y:       reg_ry = val & 11'h7FF;
            REG_RECT_W:       reg_rw = val & 12'hFFF;
            REG_RECT_H:       reg_rh = val & 12'hFFF;
            default:          reg_bs = val & 8'hFF;
        endcase
    endtask

    // Checked between edges, after the driver and the monitor have settled.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_tvalid || expected_pixels.size() != 0)
            @(negedge clk);
        // Drain requests during input emit nothing; give the block time to settle.
        repeat (30) @(posedge clk);
    endtask

    // One frame: registers, pixels with stray drains, then the tail.
    // Returns the number of pixel and tail requests queued, stray drains not counted.
    task automatic run_frame(input int unsigned fw, fh, rx, ry, rw, rh, bs,
                             input bit extremes, output int unsigned queued);
        pix_req_t    req;
        int unsigned fwc, fhc, bsc, tail;
        reg_write(REG_FRAME_WIDTH, fw);
        reg_write(REG_FRAME_HEIGHT, fh);
        reg_write(REG_RECT_X, rx);
        reg_write(REG_RECT_Y, ry);
        reg_write(REG_RECT_W, rw);
        reg_write(REG_RECT_H, rh);
        reg_write(REG_BLOCK_SIZE, bs);
        fwc  = clamp_u(fw & 12'hFFF, 1, 2048);
        fhc  = clamp_u(fh & 12'hFFF, 1, 2048);
        bsc  = clamp_u(bs & 8'hFF, MIN_BLOCK, 64);
        tail = fwc * (bsc < fhc ? bsc : fhc);
        queued = fwc * fhc + tail;
        for (int unsigned i = 0; i < fwc * fhc; i++)
        begin
            // A drain request inside the frame is ignored; never as the first request.
            if (i > 0 && $urandom_range(0, 15) == 0)
            begin
                req.drain = 1'b1;
                req.luma  = 8'($urandom);
                pending_reqs.insert(pending_reqs.size(), req);
            end
            req.drain = 1'b0;
            req.luma  = extremes ? ((i % 3 == 0) ? 8'h00 : 8'hFF) : 8'($urandom);
            pending_reqs.insert(pending_reqs.size(), req);
        end
        // A pixel in the tail is dropped and counts as a drain.
        for (int unsigned i = 0; i < tail; i++)
        begin
            req.drain = $urandom_range(0, 1);
            req.luma  = 8'($urandom);
            pending_reqs.insert(pending_reqs.size(), req);
        end
        phase_count++;
        wait_idle();
    endtask

    initial
    begin
        int unsigned n;
        int unsigned total_reqs;
        int unsigned fw, fh;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        burst_left  = 0;
        gap_left    = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
        stall_style = 0;
        cycle_count = 0;
        error_count = 0;
        reg_fw = RST_FRAME_WIDTH;
        reg_fh = RST_FRAME_HEIGHT;
        reg_rx = RST_RECT_X;
        reg_ry = RST_RECT_Y;
        reg_rw = RST_RECT_W;
        reg_rh = RST_RECT_H;
        reg_bs = RST_BLOCK_SIZE;
        in_r = 0;
        in_c = 0;
        out_r = 0;
        out_c = 0;
        latch_frame_geometry();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        total_reqs = 0;
        // Small frame with partial tiles, black and white samples, block clamped up.
        run_frame(6, 5, 1, 1, 4, 3, 0, 1'b1, n);
        total_reqs += n;
        // Zero width, corner clamped to the frame, block clamped down past the height.
        run_frame(0, 3, 2047, 2047, 2048, 2048, 255, 1'b0, n);
        total_reqs += n;
        // Wide single row with the rectangle clipped to the frame.
        run_frame(200, 1, 0, 0, 4095, 4095, 64, 1'b0, n);
        total_reqs += n;
        // Tall column where the line rows wrap and the largest block reuses its row.
        run_frame(1, 120, 0, 0, 1, 2048, 64, 1'b0, n);
        total_reqs += n;
        // Mosaic switched off.
        run_frame(7, 6, 2, 1, 0, 3, 4, 1'b0, n);
        total_reqs += n;
        run_frame(9, 9, 0, 0, 9, 9, 4, 1'b1, n);
        total_reqs += n;

        while (total_reqs < 1400)
        begin
            fw = $urandom_range(1, 24);
            fh = $urandom_range(1, 12);
            run_frame(fw, fh, $urandom_range(0, fw), $urandom_range(0, fh),
                      $urandom_range(0, fw + 2), $urandom_range(0, fh + 2),
                      ($urandom_range(0, 3) != 0) ? $urandom_range(4, 8) : $urandom_range(0, 255),
                      1'b0, n);
            total_reqs += n;
        end

        wait_idle();
        repeat (100) @(posedge clk);
        if (expected_pixels.size() != 0)
            report($sformatf("%0d predicted pixels never arrived", expected_pixels.size()));
        $display("Ran %0d frames (%0d completed) with %0d requests accepted,",
                 phase_count, frames_done, accepted_reqs);
        $display("and %0d output pixels checked against the prediction.", checked_pixels);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
